FILE: sv/slc_pkg.sv
// shared types, constants and register codes for the lru cache block
`timescale 1ns / 1ps

package slc_pkg;

	// parameter defaults
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int ADDR_WIDTH_DEF   = 64;

	// fixed field widths
	localparam int ADDR_IN_W  = 64;
	localparam int STAMP_W    = 64;
	localparam int TOTAL_W    = 32;
	localparam int WAY_OUT_W  = 3;
	localparam int WCNT_W     = 6;
	localparam int SB_W       = 5;
	localparam int SHIFT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	// register reset values
	localparam logic [2:0] SET_BITS_RST   = 3'd1;
	localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
	localparam logic [3:0] WAYS_RST       = 4'd1;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [4:0] block_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

endpackage

FILE: sv/slc_queue.sv
// small fifo between the classifying front and the lookup back end
`timescale 1ns / 1ps

module slc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/slc_front.sv
// front end: accepts addresses and splits them into set index and tag
`timescale 1ns / 1ps

module slc_front #(
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
	parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
	input  slc_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [slc_pkg::ADDR_IN_W-1:0]   address,
	input  logic                            q_full,
	input  logic                            clearing,
	output logic                            q_push,
	output logic [MAX_SET_BITS-1:0]         item_set,
	output logic [ADDR_WIDTH-1:0]           item_tag
);

	import slc_pkg::*;

	localparam int SW = MAX_SET_BITS;

	logic [ADDR_WIDTH-1:0] addr_m;
	logic [SB_W-1:0]       s_raw;
	logic [SB_W-1:0]       s_eff;
	logic [SHIFT_W-1:0]    shamt;
	logic [SW-1:0]         set_mask;

	// hold off while the store is swept or the queue is full
	assign in_stall = q_full || clearing;
	assign q_push   = in_valid && !in_stall;

	// set bits clamp and shift amounts
	always_comb begin
		addr_m   = address[ADDR_WIDTH-1:0];
		s_raw    = SB_W'(cfg.set_bits);
		s_eff    = (s_raw > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : s_raw;
		shamt    = SHIFT_W'(s_eff) + SHIFT_W'(cfg.block_bits);
		set_mask = ~({SW{1'b1}} << s_eff);
		item_set = SW'(addr_m >> cfg.block_bits) & set_mask;
		item_tag = addr_m >> shamt;
	end

endmodule

FILE: sv/slc_back.sv
// back end: set lookup, lru victim choice, store update and result register
`timescale 1ns / 1ps

module slc_back #(
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slc_pkg::cfg_t                     cfg,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic [MAX_SET_BITS-1:0]           q_set,
	input  logic [ADDR_WIDTH-1:0]             q_tag,
	output logic                              clearing,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic                              miss,
	output logic                              eviction,
	output logic [slc_pkg::WAY_OUT_W-1:0]     way_used,
	output logic [slc_pkg::TOTAL_W-1:0]       hit_total,
	output logic [slc_pkg::TOTAL_W-1:0]       miss_total,
	output logic [slc_pkg::TOTAL_W-1:0]       eviction_total
);

	import slc_pkg::*;

	localparam int SW    = MAX_SET_BITS;
	localparam int ROWS  = 1 << SW;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_SCAN  = 4'b1000
	} state_t;

	// set store, one row per set
	logic [MAX_WAYS-1:0]                 valid_mem [ROWS];
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [ROWS];
	logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp_mem [ROWS];

	logic [MAX_WAYS-1:0]                 rd_valid_q;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_q;
	logic [MAX_WAYS-1:0][STAMP_W-1:0]    rd_stamp_q;
	logic [SW-1:0]                       set_q;
	logic [ADDR_WIDTH-1:0]               tag_q;

	state_t              state_q;
	logic [SW-1:0]       clr_idx_q;
	logic [WCNT_W-1:0]   scan_idx_q;
	logic [STAMP_W-1:0]  best_q;
	logic [WAY_W-1:0]    best_way_q;
	logic [STAMP_W-1:0]  use_ctr_q;
	logic [TOTAL_W-1:0]  hit_cnt_q;
	logic [TOTAL_W-1:0]  miss_cnt_q;
	logic [TOTAL_W-1:0]  evict_cnt_q;

	logic                out_valid_q;
	logic                hit_q;
	logic                miss_q;
	logic                evict_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [TOTAL_W-1:0]  hit_tot_q;
	logic [TOTAL_W-1:0]  miss_tot_q;
	logic [TOTAL_W-1:0]  evict_tot_q;

	logic [WCNT_W-1:0]   ways_raw;
	logic [WCNT_W-1:0]   ways_eff;
	logic [MAX_WAYS-1:0] used_vec;
	logic [MAX_WAYS-1:0] match_vec;
	logic [MAX_WAYS-1:0] free_vec;
	logic                hit_any;
	logic                free_any;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [STAMP_W-1:0]  cand;
	logic                cand_lt;
	logic                scan_last;
	logic                fin_ready;
	logic                fin_hit;
	logic                fin_evict;
	logic [WAY_W-1:0]    fin_way;
	logic                go_scan;
	logic                out_free;
	logic                finish;
	logic [MAX_WAYS-1:0]                 wr_valid_row;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tag_row;
	logic [MAX_WAYS-1:0][STAMP_W-1:0]    wr_stamp_row;
	logic [TOTAL_W-1:0]  hit_cnt_nxt;
	logic [TOTAL_W-1:0]  miss_cnt_nxt;
	logic [TOTAL_W-1:0]  evict_cnt_nxt;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == '1) ? v : v + TOTAL_W'(1);
	endfunction

	// ways in use, clamped to one..MAX_WAYS
	always_comb begin
		ways_raw = WCNT_W'(cfg.ways_in_use);
		if (ways_raw == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (ways_raw > WCNT_W'(MAX_WAYS)) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = ways_raw;
		end
	end

	// tag compare and first free way over the read row
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			used_vec[w]  = (WCNT_W'(w) < ways_eff);
			match_vec[w] = used_vec[w] && rd_valid_q[w] && (rd_tag_q[w] == tag_q);
			free_vec[w]  = used_vec[w] && !rd_valid_q[w];
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match_vec[w]) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (free_vec[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// one stamp compare per cycle while hunting the victim
	assign cand      = rd_stamp_q[scan_idx_q[WAY_W-1:0]];
	assign cand_lt   = (cand < best_q);
	assign scan_last = (scan_idx_q == ways_eff - WCNT_W'(1));

	// decide how the current item completes
	always_comb begin
		fin_ready = 1'b0;
		fin_hit   = 1'b0;
		fin_evict = 1'b0;
		fin_way   = '0;
		go_scan   = 1'b0;
		case (state_q)
			ST_LOOK: begin
				if (hit_any) begin
					fin_ready = 1'b1;
					fin_hit   = 1'b1;
					fin_way   = hit_way;
				end else if (free_any) begin
					fin_ready = 1'b1;
					fin_way   = free_way;
				end else if (ways_eff == WCNT_W'(1)) begin
					fin_ready = 1'b1;
					fin_evict = 1'b1;
				end else begin
					go_scan = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					fin_ready = 1'b1;
					fin_evict = 1'b1;
					fin_way   = cand_lt ? scan_idx_q[WAY_W-1:0] : best_way_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = fin_ready && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign clearing = (state_q == ST_CLEAR);

	// updated row and totals
	always_comb begin
		wr_valid_row          = rd_valid_q;
		wr_tag_row            = rd_tag_q;
		wr_stamp_row          = rd_stamp_q;
		wr_valid_row[fin_way] = 1'b1;
		wr_tag_row[fin_way]   = tag_q;
		wr_stamp_row[fin_way] = use_ctr_q;
		hit_cnt_nxt   = fin_hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
		miss_cnt_nxt  = fin_hit ? miss_cnt_q : sat_inc(miss_cnt_q);
		evict_cnt_nxt = fin_evict ? sat_inc(evict_cnt_q) : evict_cnt_q;
	end

	// store writes: sweep after reset, row update on completion
	always_ff @(posedge clk) begin
		if (clearing) begin
			valid_mem[clr_idx_q] <= '0;
		end else if (finish) begin
			valid_mem[set_q] <= wr_valid_row;
		end
		if (finish) begin
			tag_mem[set_q]   <= wr_tag_row;
			stamp_mem[set_q] <= wr_stamp_row;
		end
	end

	// registered row read and item capture
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_valid_q <= valid_mem[q_set];
			rd_tag_q   <= tag_mem[q_set];
			rd_stamp_q <= stamp_mem[q_set];
			set_q      <= q_set;
			tag_q      <= q_tag;
		end
	end

	// sequencer, stamp counter and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			best_q      <= '0;
			best_way_q  <= '0;
			use_ctr_q   <= STAMP_W'(1);
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SW'(1);
					if (clr_idx_q == {SW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (go_scan) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= WCNT_W'(1);
						best_q     <= rd_stamp_q[0];
						best_way_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						if (finish) begin
							state_q <= ST_IDLE;
						end
					end else begin
						if (cand_lt) begin
							best_q     <= cand;
							best_way_q <= scan_idx_q[WAY_W-1:0];
						end
						scan_idx_q <= scan_idx_q + WCNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				use_ctr_q   <= use_ctr_q + STAMP_W'(1);
				hit_cnt_q   <= hit_cnt_nxt;
				miss_cnt_q  <= miss_cnt_nxt;
				evict_cnt_q <= evict_cnt_nxt;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q       <= fin_hit;
			miss_q      <= !fin_hit;
			evict_q     <= fin_evict;
			way_q       <= WAY_OUT_W'(fin_way);
			hit_tot_q   <= hit_cnt_nxt;
			miss_tot_q  <= miss_cnt_nxt;
			evict_tot_q <= evict_cnt_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign miss           = miss_q;
	assign eviction       = evict_q;
	assign way_used       = way_q;
	assign hit_total      = hit_tot_q;
	assign miss_total     = miss_tot_q;
	assign eviction_total = evict_tot_q;

`ifndef ASSERT_OFF
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hit_q != miss_q))
		else $error("hit and miss flags not exclusive");
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evict_q) |-> miss_q)
		else $error("eviction reported without a miss");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((scan_idx_q != '0) && (scan_idx_q < ways_eff)))
		else $error("victim scan index out of range");
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && fin_hit) |-> rd_valid_q[fin_way])
		else $error("hit on an invalid line");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && fin_evict) |-> ((rd_valid_q & used_vec) == used_vec))
		else $error("eviction while a free way exists");
`endif

endmodule

FILE: sv/set_assoc_lru_cache_model.sv
// top level of the set-associative cache lookup with lru replacement
// the idle back end pops a queued address and registers its set row; a hit or
// a fill of a free way then completes into the result register, while a miss
// in a full set of more than one way first scans the stamps, one per cycle;
// the back end takes one item at a time, popping the next once the last has
// written its row; reset: registers to defaults, stamp counter to 1, totals
// to 0; the valid store is swept one set per cycle, while input is stalled
`timescale 1ns / 1ps

module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [slc_pkg::ADDR_IN_W-1:0]   address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic                            miss,
	output logic                            eviction,
	output logic [slc_pkg::WAY_OUT_W-1:0]   way_used,
	output logic [slc_pkg::TOTAL_W-1:0]     hit_total,
	output logic [slc_pkg::TOTAL_W-1:0]     miss_total,
	output logic [slc_pkg::TOTAL_W-1:0]     eviction_total
);

	import slc_pkg::*;

	localparam int QW = MAX_SET_BITS + ADDR_WIDTH;

	cfg_t                  cfg_q;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	logic                  clearing;
	logic [MAX_SET_BITS-1:0] item_set;
	logic [ADDR_WIDTH-1:0] item_tag;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= SET_BITS_RST;
			cfg_q.block_bits  <= BLOCK_BITS_RST;
			cfg_q.ways_in_use <= WAYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_BITS:   cfg_q.set_bits    <= cfg_data[2:0];
				REG_BLOCK_BITS: cfg_q.block_bits  <= cfg_data[4:0];
				REG_WAYS:       cfg_q.ways_in_use <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// front end
	slc_front #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_front (
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.address  (address),
		.q_full   (q_full),
		.clearing (clearing),
		.q_push   (q_push),
		.item_set (item_set),
		.item_tag (item_tag)
	);

	// queue between front and back
	assign q_wdata = {item_set, item_tag};

	slc_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// back end
	slc_back #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.q_set          (q_rdata[QW-1:ADDR_WIDTH]),
		.q_tag          (q_rdata[ADDR_WIDTH-1:0]),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.miss           (miss),
		.eviction       (eviction),
		.way_used       (way_used),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

endmodule
